/* rtl/izba_pkg.sv */
`default_nettype none

package izba_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned NUM_W     = 16;
  localparam int unsigned EXT_W     = NUM_W + 1;
  localparam int unsigned SUM_W     = NUM_W + 2;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MB_W      = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned WORD_SH   = 5;

  localparam logic [REQ_W-1:0] REQ_ALLOC_INODE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE_INODE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALLOC_ZONE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_FREE_ZONE   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE         = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ALREADY_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_INODE_MAP_BLOCKS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_MAP_BLOCKS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INODE_COUNT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA_ZONE  = 3'd4;

endpackage

`default_nettype wire

/* rtl/inode_zone_bitmap_allocator_unit.sv */
// Inode and zone free-space bitmap allocator.
// Input channel (in_valid_i/in_ready_o) carries one request word: req_type_i and
// item_number_i. Output channel (out_valid_o/out_ready_i) returns one word per
// request: status_o and allocated_number_o. The config channel (cfg_valid_i,
// cfg_index_i, cfg_data_i) is always ready and writes the five registers.
// Requests are handled one at a time. A free reads its bitmap word, clears the
// bit in S_FREE and loads its result into the output register from S_RESP; a
// rejected request (range, missing block, no block in use) goes straight from
// S_IDLE to S_RESP. An allocation scans bitmap words in S_SCAN through the
// single read port of its memory, one word per cycle, up to map blocks in use *
// BITS_PER_MAP_BLOCK / 32 words (2048 with the default sizes), then sets the
// found bit in S_ALLOC. The next request can be taken in the cycle after a
// result is loaded. The result sits in an output register, so a stalled
// receiver holds the finished word while the block accepts and works on the
// next request; a second result waits internally until the output register is
// taken. After reset a clearing pass writes every word of both bitmap memories
// (one word per cycle, bit 0 left set); no request is accepted during it,
// config writes are.
`default_nettype none

module inode_zone_bitmap_allocator_unit #(
  parameter int unsigned BITS_PER_MAP_BLOCK = 8192,
  parameter int unsigned INODE_MAP_SLOTS    = 8,
  parameter int unsigned ZONE_MAP_SLOTS     = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [izba_pkg::REQ_W-1:0]        req_type_i,
  input  logic [izba_pkg::NUM_W-1:0]        item_number_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [izba_pkg::STATUS_W-1:0]     status_o,
  output logic [izba_pkg::NUM_W-1:0]        allocated_number_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [izba_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [izba_pkg::NUM_W-1:0]        cfg_data_i
);
  import izba_pkg::*;

  localparam int unsigned WPB         = BITS_PER_MAP_BLOCK / WORD_W;
  localparam int unsigned INODE_WORDS = INODE_MAP_SLOTS * WPB;
  localparam int unsigned ZONE_WORDS  = ZONE_MAP_SLOTS * WPB;
  localparam int unsigned MAX_WORDS   = (INODE_WORDS > ZONE_WORDS) ? INODE_WORDS : ZONE_WORDS;
  localparam int unsigned IAW         = $clog2(INODE_WORDS);
  localparam int unsigned ZAW         = $clog2(ZONE_WORDS);
  localparam int unsigned AW          = $clog2(MAX_WORDS);
  localparam int unsigned CW          = AW + 1;
  localparam int unsigned BLK_SH      = $clog2(BITS_PER_MAP_BLOCK);
  localparam int unsigned WPB_SH      = BLK_SH - WORD_SH;
  localparam int unsigned POS_W       = AW + WORD_SH;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_ALLOC,
    S_RESP
  } state_e;

  state_e state_q;

  logic [MB_W-1:0]     inode_map_blocks_q;
  logic [MB_W-1:0]     zone_map_blocks_q;
  logic [NUM_W-1:0]    inode_count_q;
  logic [NUM_W-1:0]    zone_count_q;
  logic [NUM_W-1:0]    first_data_zone_q;

  logic                zone_sel_q;
  logic [CW-1:0]       scan_q;
  logic [CW-1:0]       total_q;
  logic                rd_pend_q;
  logic [AW-1:0]       addr_q;
  logic [WORD_SH-1:0]  bidx_q;
  logic [WORD_W-1:0]   word_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [NUM_W-1:0]    res_num_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [NUM_W-1:0]    number_q;

  logic [WORD_W-1:0]   inode_mem [INODE_WORDS];
  logic [WORD_W-1:0]   zone_mem [ZONE_WORDS];
  logic [WORD_W-1:0]   i_rdata_q;
  logic [WORD_W-1:0]   z_rdata_q;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_map_blocks_q <= '0;
      zone_map_blocks_q  <= '0;
      inode_count_q      <= '0;
      zone_count_q       <= '0;
      first_data_zone_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_INODE_MAP_BLOCKS: inode_map_blocks_q <= cfg_data_i[MB_W-1:0];
        CFG_ZONE_MAP_BLOCKS:  zone_map_blocks_q  <= cfg_data_i[MB_W-1:0];
        CFG_INODE_COUNT:      inode_count_q      <= cfg_data_i;
        CFG_ZONE_COUNT:       zone_count_q       <= cfg_data_i;
        CFG_FIRST_DATA_ZONE:  first_data_zone_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request decode
  logic [MB_W-1:0]   nb_inode, nb_zone;
  logic [EXT_W-1:0]  num_ext, zbit;
  logic              ifree_range_bad, ifree_blk_bad, zfree_range_bad, zfree_blk_bad;
  logic [AW-1:0]     free_addr;
  logic [WORD_SH-1:0] free_bidx;

  always_comb begin
    nb_inode = (inode_map_blocks_q > MB_W'(INODE_MAP_SLOTS)) ? MB_W'(INODE_MAP_SLOTS)
                                                              : inode_map_blocks_q;
    nb_zone  = (zone_map_blocks_q > MB_W'(ZONE_MAP_SLOTS)) ? MB_W'(ZONE_MAP_SLOTS)
                                                            : zone_map_blocks_q;
    num_ext  = {1'b0, item_number_i};
    zbit     = num_ext - {1'b0, first_data_zone_q} + EXT_W'(1);
    ifree_range_bad = (item_number_i == '0) || (item_number_i > inode_count_q);
    ifree_blk_bad   = (num_ext >> BLK_SH) >= EXT_W'(nb_inode);
    zfree_range_bad = (item_number_i < first_data_zone_q) || (item_number_i >= zone_count_q);
    zfree_blk_bad   = (zbit >> BLK_SH) >= EXT_W'(nb_zone);
    if (req_type_i == REQ_FREE_ZONE) begin
      free_addr = zbit[POS_W-1:WORD_SH];
      free_bidx = zbit[WORD_SH-1:0];
    end else begin
      free_addr = num_ext[POS_W-1:WORD_SH];
      free_bidx = num_ext[WORD_SH-1:0];
    end
  end

  // word datapath
  logic [WORD_W-1:0]  rword;
  logic [WORD_SH-1:0] alloc_bidx;
  logic [POS_W-1:0]   pos;
  logic [SUM_W-1:0]   pos_ext, zsum, zone_num;
  logic               alloc_ok;
  logic [NUM_W-1:0]   alloc_num;
  logic [WORD_W-1:0]  set_word, clr_word;
  logic               was_set;
  logic               scan_issue, scan_found;
  logic               wb_en;
  logic [WORD_W-1:0]  wb_word;

  always_comb begin
    rword      = zone_sel_q ? z_rdata_q : i_rdata_q;
    alloc_bidx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!word_q[i]) alloc_bidx = WORD_SH'(i);
    end
    pos       = {addr_q, alloc_bidx};
    pos_ext   = SUM_W'(pos);
    zsum      = pos_ext + SUM_W'(first_data_zone_q);
    zone_num  = zsum - SUM_W'(1);
    alloc_ok  = zone_sel_q ? ((zsum != '0) && (zone_num < SUM_W'(zone_count_q)))
                           : (pos_ext <= SUM_W'(inode_count_q));
    alloc_num = zone_sel_q ? zone_num[NUM_W-1:0] : pos_ext[NUM_W-1:0];
    set_word  = word_q | (WORD_W'(1) << alloc_bidx);
    clr_word  = rword & ~(WORD_W'(1) << bidx_q);
    was_set   = rword[bidx_q];
    scan_issue = scan_q < total_q;
    scan_found = rd_pend_q && (~rword != '0);
    wb_en   = 1'b0;
    wb_word = clr_word;
    case (state_q)
      S_FREE:  wb_en = 1'b1;
      S_ALLOC: begin
        wb_en   = alloc_ok;
        wb_word = set_word;
      end
      default: ;
    endcase
  end

  // bitmap memories
  logic [AW-1:0]     rd_addr;
  logic              clearing;
  logic [WORD_W-1:0] clr_val;
  logic              i_we, z_we;
  logic [IAW-1:0]    i_waddr;
  logic [ZAW-1:0]    z_waddr;
  logic [WORD_W-1:0] mem_wdata;

  always_comb begin
    rd_addr   = (state_q == S_IDLE) ? free_addr : scan_q[AW-1:0];
    clearing  = (state_q == S_CLEAR);
    clr_val   = (scan_q == '0) ? WORD_W'(1) : '0;
    i_we      = clearing ? (scan_q < CW'(INODE_WORDS)) : (wb_en && !zone_sel_q);
    z_we      = clearing ? (scan_q < CW'(ZONE_WORDS)) : (wb_en && zone_sel_q);
    i_waddr   = clearing ? scan_q[IAW-1:0] : addr_q[IAW-1:0];
    z_waddr   = clearing ? scan_q[ZAW-1:0] : addr_q[ZAW-1:0];
    mem_wdata = clearing ? clr_val : wb_word;
  end

  always_ff @(posedge clk_i) begin
    if (i_we) inode_mem[i_waddr] <= mem_wdata;
    i_rdata_q <= inode_mem[rd_addr[IAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (z_we) zone_mem[z_waddr] <= mem_wdata;
    z_rdata_q <= zone_mem[rd_addr[ZAW-1:0]];
  end

  // control
  logic out_load;
  logic out_valid_d;

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign allocated_number_o = number_q;

  always_comb begin
    out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q && !out_ready_i;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      zone_sel_q   <= 1'b0;
      scan_q       <= '0;
      total_q      <= '0;
      rd_pend_q    <= 1'b0;
      addr_q       <= '0;
      bidx_q       <= '0;
      word_q       <= '0;
      res_status_q <= ST_OK;
      res_num_q    <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      number_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_CLEAR: begin
          scan_q <= scan_q + CW'(1);
          if (scan_q == CW'(MAX_WORDS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            zone_sel_q   <= (req_type_i == REQ_ALLOC_ZONE) || (req_type_i == REQ_FREE_ZONE);
            res_num_q    <= '0;
            scan_q       <= '0;
            rd_pend_q    <= 1'b0;
            addr_q       <= free_addr;
            bidx_q       <= free_bidx;
            case (req_type_i)
              REQ_ALLOC_INODE: begin
                total_q <= CW'(nb_inode) << WPB_SH;
                if (nb_inode == '0) begin
                  res_status_q <= ST_NONE_FREE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              REQ_ALLOC_ZONE: begin
                total_q <= CW'(nb_zone) << WPB_SH;
                if (nb_zone == '0) begin
                  res_status_q <= ST_NONE_FREE;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              REQ_FREE_INODE: begin
                if (ifree_range_bad) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_RESP;
                end else if (ifree_blk_bad) begin
                  res_status_q <= ST_NO_BLOCK;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_FREE;
                end
              end
              REQ_FREE_ZONE: begin
                if (zfree_range_bad) begin
                  res_status_q <= ST_RANGE;
                  state_q      <= S_RESP;
                end else if (zfree_blk_bad) begin
                  res_status_q <= ST_NO_BLOCK;
                  state_q      <= S_RESP;
                end else begin
                  state_q <= S_FREE;
                end
              end
              default: begin
                res_status_q <= ST_NONE_FREE;
                state_q      <= S_RESP;
              end
            endcase
          end
        end
        S_FREE: begin
          res_status_q <= was_set ? ST_OK : ST_ALREADY_CLEAR;
          state_q      <= S_RESP;
        end
        S_SCAN: begin
          if (scan_found) begin
            word_q    <= rword;
            rd_pend_q <= 1'b0;
            state_q   <= S_ALLOC;
          end else if (!scan_issue) begin
            rd_pend_q    <= 1'b0;
            res_status_q <= ST_NONE_FREE;
            state_q      <= S_RESP;
          end else begin
            scan_q    <= scan_q + CW'(1);
            addr_q    <= scan_q[AW-1:0];
            rd_pend_q <= 1'b1;
          end
        end
        S_ALLOC: begin
          res_status_q <= alloc_ok ? ST_OK : ST_NONE_FREE;
          res_num_q    <= alloc_ok ? alloc_num : '0;
          state_q      <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            status_q    <= res_status_q;
            number_q    <= res_num_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("output word loaded outside the response state");

  a_alloc_sets_one_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && alloc_ok) |-> ($countones(set_word) == $countones(word_q) + 1))
    else $error("allocation writeback does not set exactly one bit");

  a_fail_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (allocated_number_o == '0))
    else $error("failed request returns a nonzero number");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import izba_pkg::*;

  localparam int MAP_BITS      = 8192;
  localparam int SLOTS         = 8;
  localparam int WORDS_PER_BLK = MAP_BITS / WORD_W;
  localparam int MAP_WORDS     = SLOTS * WORDS_PER_BLK;
  localparam int HOLD_AT       = 120;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 45;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NUM_W-1:0]    number;
  } reply_t;

  class free_map_scoreboard;
    logic [WORD_W-1:0] inode_map [MAP_WORDS];
    logic [WORD_W-1:0] zone_map [MAP_WORDS];
    logic [MB_W-1:0]   inode_blocks;
    logic [MB_W-1:0]   zone_blocks;
    logic [NUM_W-1:0]  inode_limit;
    logic [NUM_W-1:0]  zone_limit;
    logic [NUM_W-1:0]  data_zone_base;
    reply_t            replies_due[$];
    int                n_mismatch;

    function new();
      foreach (inode_map[i]) begin
        inode_map[i] = '0;
        zone_map[i] = '0;
      end
      inode_map[0][0] = 1'b1;
      zone_map[0][0] = 1'b1;
      inode_blocks = '0;
      zone_blocks = '0;
      inode_limit = '0;
      zone_limit = '0;
      data_zone_base = '0;
      n_mismatch = 0;
    endfunction

    task report(string msg);
      n_mismatch++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] data);
      case (idx)
        CFG_INODE_MAP_BLOCKS: inode_blocks = data[MB_W-1:0];
        CFG_ZONE_MAP_BLOCKS:  zone_blocks = data[MB_W-1:0];
        CFG_INODE_COUNT:      inode_limit = data;
        CFG_ZONE_COUNT:       zone_limit = data;
        CFG_FIRST_DATA_ZONE:  data_zone_base = data;
        default: ;
      endcase
    endfunction

    function int blocks_in_use(logic [MB_W-1:0] r);
      return (int'(r) > SLOTS) ? SLOTS : int'(r);
    endfunction

    // lowest clear bit over the map blocks in use
    function bit first_clear(bit zone_side, int nblk, output int pos);
      logic [WORD_W-1:0] w;
      pos = 0;
      for (int i = 0; i < nblk * WORDS_PER_BLK; i++) begin
        w = zone_side ? zone_map[i] : inode_map[i];
        if (w != '1) begin
          for (int b = 0; b < WORD_W; b++) begin
            if (!w[b]) begin
              pos = i * WORD_W + b;
              return 1'b1;
            end
          end
        end
      end
      return 1'b0;
    endfunction

    function logic [STATUS_W-1:0] drop_bit(bit zone_side, int bitpos);
      logic was_set;
      if (zone_side) begin
        was_set = zone_map[bitpos / WORD_W][bitpos % WORD_W];
        zone_map[bitpos / WORD_W][bitpos % WORD_W] = 1'b0;
      end else begin
        was_set = inode_map[bitpos / WORD_W][bitpos % WORD_W];
        inode_map[bitpos / WORD_W][bitpos % WORD_W] = 1'b0;
      end
      return was_set ? ST_OK : ST_ALREADY_CLEAR;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [NUM_W-1:0] num);
      reply_t r;
      int     nb;
      int     pos;
      int     zone;
      int     bitpos;
      r.status = ST_OK;
      r.number = '0;
      case (req)
        REQ_ALLOC_INODE: begin
          nb = blocks_in_use(inode_blocks);
          if (!first_clear(1'b0, nb, pos) || pos > int'(inode_limit)) begin
            r.status = ST_NONE_FREE;
          end else begin
            inode_map[pos / WORD_W][pos % WORD_W] = 1'b1;
            r.number = NUM_W'(pos);
          end
        end
        REQ_FREE_INODE: begin
          nb = blocks_in_use(inode_blocks);
          if (int'(num) < 1 || int'(num) > int'(inode_limit)) r.status = ST_RANGE;
          else if (int'(num) / MAP_BITS >= nb) r.status = ST_NO_BLOCK;
          else r.status = drop_bit(1'b0, int'(num));
        end
        REQ_ALLOC_ZONE: begin
          nb = blocks_in_use(zone_blocks);
          if (!first_clear(1'b1, nb, pos)) begin
            r.status = ST_NONE_FREE;
          end else begin
            zone = pos - 1 + int'(data_zone_base);
            if (zone < 0 || zone >= int'(zone_limit)) begin
              r.status = ST_NONE_FREE;
            end else begin
              zone_map[pos / WORD_W][pos % WORD_W] = 1'b1;
              r.number = NUM_W'(zone);
            end
          end
        end
        default: begin
          nb = blocks_in_use(zone_blocks);
          if (int'(num) < int'(data_zone_base) || int'(num) >= int'(zone_limit)) begin
            r.status = ST_RANGE;
          end else begin
            bitpos = int'(num) - int'(data_zone_base) + 1;
            if (bitpos / MAP_BITS >= nb) r.status = ST_NO_BLOCK;
            else r.status = drop_bit(1'b1, bitpos);
          end
        end
      endcase
      replies_due.push_back(r);
    endfunction

    task check_reply(logic [STATUS_W-1:0] status, logic [NUM_W-1:0] number);
      reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("unexpected word status %0d number %0d", status, number));
        return;
      end
      want = replies_due.pop_front();
      if (status !== want.status)
        report($sformatf("status got %0d want %0d", status, want.status));
      if (number !== want.number)
        report($sformatf("allocated_number got %0d want %0d", number, want.number));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i = '0;
  logic [NUM_W-1:0]     item_number_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [STATUS_W-1:0]  status_o;
  logic [NUM_W-1:0]     allocated_number_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [NUM_W-1:0]     cfg_data_i = '0;

  free_map_scoreboard sb;
  bit                 no_idle = 1'b0;

  inode_zone_bitmap_allocator_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .req_type_i         (req_type_i),
    .item_number_i      (item_number_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .allocated_number_o (allocated_number_o),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.set_register(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && in_ready_o) sb.note_request(req_type_i, item_number_i);
    if (rst_ni && out_valid_o && out_ready_i) sb.check_reply(status_o, allocated_number_o);
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(logic [REQ_W-1:0] req, logic [NUM_W-1:0] num);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    item_number_i <= num;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.replies_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : reply_sink
    int gap;
    int taken;
    taken = 0;
    wait (rst_ni === 1'b1);
    forever begin
      if (taken == HOLD_AT) begin
        // long stall so the block backs up into its input
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  initial begin : stimulus
    logic [NUM_W-1:0] d;
    logic [NUM_W-1:0] num;
    logic [MB_W-1:0]  blk;
    int               lim;
    int               base;
    int               r;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers at reset: nothing in use, all counts zero
    send_request(REQ_ALLOC_INODE, 16'($urandom));
    send_request(REQ_FREE_INODE, 16'h0000);
    send_request(REQ_ALLOC_ZONE, 16'($urandom));
    send_request(REQ_FREE_ZONE, 16'h0000);
    wait_idle();

    write_reg(CFG_INODE_MAP_BLOCKS, 16'hffff);
    write_reg(CFG_ZONE_MAP_BLOCKS, 16'h0001);
    write_reg(CFG_INODE_COUNT, 16'hffff);
    write_reg(CFG_ZONE_COUNT, 16'hffff);
    write_reg(CFG_FIRST_DATA_ZONE, 16'h0000);
    for (int k = int'(CFG_FIRST_DATA_ZONE) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), 16'($urandom));

    send_request(REQ_ALLOC_INODE, 16'hffff);
    send_request(REQ_ALLOC_INODE, 16'h0000);
    send_request(REQ_FREE_INODE, 16'd1);
    send_request(REQ_FREE_INODE, 16'd1);
    send_request(REQ_ALLOC_INODE, 16'($urandom));
    send_request(REQ_FREE_INODE, 16'hffff);
    send_request(REQ_FREE_INODE, 16'h0000);
    send_request(REQ_ALLOC_ZONE, 16'($urandom));
    send_request(REQ_ALLOC_ZONE, 16'($urandom));
    send_request(REQ_FREE_ZONE, 16'd0);
    send_request(REQ_FREE_ZONE, 16'd8191);
    send_request(REQ_FREE_ZONE, 16'hffff);
    send_request(REQ_FREE_ZONE, 16'd8190);
    wait_idle();

    // found bit past the count, zone base at the top
    write_reg(CFG_INODE_COUNT, 16'd2);
    write_reg(CFG_ZONE_MAP_BLOCKS, 16'h0008);
    write_reg(CFG_FIRST_DATA_ZONE, 16'hffff);
    send_request(REQ_ALLOC_INODE, 16'($urandom));
    send_request(REQ_FREE_INODE, 16'd3);
    send_request(REQ_FREE_INODE, 16'd2);
    send_request(REQ_ALLOC_INODE, 16'($urandom));
    send_request(REQ_ALLOC_ZONE, 16'($urandom));
    send_request(REQ_FREE_ZONE, 16'hffff);
    send_request(REQ_FREE_ZONE, 16'hfffe);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      for (int s = 0; s < 2; s++) begin
        case ($urandom_range(0, 5))
          0: blk = 4'd0;
          1, 2: blk = 4'd1;
          3: blk = 4'd2;
          4: blk = 4'd8;
          default: blk = MB_W'($urandom_range(9, 15));
        endcase
        d = 16'($urandom);
        d[MB_W-1:0] = blk;
        write_reg((s == 0) ? CFG_INODE_MAP_BLOCKS : CFG_ZONE_MAP_BLOCKS, d);
      end
      case ($urandom_range(0, 3))
        0: lim = $urandom_range(1, 8);
        1: lim = $urandom_range(20, 300);
        2: lim = 65535;
        default: lim = $urandom_range(0, 65535);
      endcase
      write_reg(CFG_INODE_COUNT, 16'(lim));
      case ($urandom_range(0, 3))
        0: base = 0;
        1: base = $urandom_range(1, 100);
        2: base = $urandom_range(0, 65535);
        default: base = 65535 - $urandom_range(0, 40);
      endcase
      write_reg(CFG_FIRST_DATA_ZONE, 16'(base));
      case ($urandom_range(0, 3))
        0: lim = base + $urandom_range(1, 20);
        1: lim = base + $urandom_range(50, 300);
        2: lim = 65535;
        default: lim = $urandom_range(0, 65535);
      endcase
      if (lim > 65535) lim = 65535;
      write_reg(CFG_ZONE_COUNT, 16'(lim));

      no_idle = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        num = 16'($urandom);
        if (r < 35) begin
          send_request(REQ_ALLOC_INODE, num);
        end else if (r < 55) begin
          // mostly frees of numbers that allocation has handed out
          if ($urandom_range(0, 9) < 8) num = 16'($urandom_range(1, 48));
          send_request(REQ_FREE_INODE, num);
        end else if (r < 80) begin
          send_request(REQ_ALLOC_ZONE, num);
        end else begin
          if ($urandom_range(0, 9) < 8) num = 16'(base + $urandom_range(0, 48));
          send_request(REQ_FREE_ZONE, num);
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.replies_due.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.replies_due.size()));
    if (sb.n_mismatch == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
